[rtl/core/i2cm_pkg.sv]
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int TICKS_W   = 10;
    localparam int TIMEOUT_W = 8;
    localparam int CFG_W     = 10;
    localparam int US_W      = 4;
    localparam int PROD_W    = TICKS_W + US_W;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 4;
    localparam int TDATA_W   = 16;

    localparam logic [0:0] CFG_TICKS_PER_US = 1'd0;
    localparam logic [0:0] CFG_ACK_TIMEOUT  = 1'd1;

    localparam logic [TICKS_W-1:0]   TICKS_RESET   = 10'd72;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_WAIT  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // phase lengths in microseconds
    localparam logic [US_W-1:0] US_1  = 4'd1;
    localparam logic [US_W-1:0] US_2  = 4'd2;
    localparam logic [US_W-1:0] US_5  = 4'd5;
    localparam logic [US_W-1:0] US_6  = 4'd6;
    localparam logic [US_W-1:0] US_10 = 4'd10;

    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [16:0] {
        PH_IDLE    = 17'h00001,
        PH_ST_A    = 17'h00002,
        PH_ST_B    = 17'h00004,
        PH_ST_C    = 17'h00008,
        PH_SP_A    = 17'h00010,
        PH_SP_B    = 17'h00020,
        PH_WR_SET  = 17'h00040,
        PH_WR_HI   = 17'h00080,
        PH_WR_LO   = 17'h00100,
        PH_WA_REL  = 17'h00200,
        PH_WA_HI   = 17'h00400,
        PH_WA_POLL = 17'h00800,
        PH_RD_LO   = 17'h01000,
        PH_RD_HI   = 17'h02000,
        PH_RD_HOLD = 17'h04000,
        PH_AK_SET  = 17'h08000,
        PH_AK_HI   = 17'h10000
    } t_phase;

    typedef struct packed {
        logic              sda_in;
        logic              send_ack;
        logic [BYTE_W-1:0] tx_byte;
        logic [2:0]        cmd;
        logic              cmd_valid;
    } t_item;

    typedef struct packed {
        logic              ack_error;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_oe;
        logic              sda_out;
        logic              scl_out;
    } t_result;

    typedef struct packed {
        logic [TICKS_W-1:0]   ticks_per_us;
        logic [TIMEOUT_W-1:0] ack_timeout_polls;
    } t_cfg;

endpackage

[rtl/core/i2cm_delay_calc.sv]
`timescale 1ns / 1ps

module i2cm_delay_calc #(
    parameter int DELAY_COUNT_WIDTH = 16
) (
    input  logic [i2cm_pkg::US_W-1:0]    i_us,
    input  logic [i2cm_pkg::TICKS_W-1:0] i_ticks_per_us,
    output logic [DELAY_COUNT_WIDTH-1:0] o_count
);
    import i2cm_pkg::*;

    localparam int XW = (DELAY_COUNT_WIDTH > PROD_W) ? DELAY_COUNT_WIDTH : PROD_W;

    logic [PROD_W-1:0] prod;
    logic [XW-1:0]     prod_x;
    logic [XW-1:0]     max_x;

    assign prod   = PROD_W'(i_us) * PROD_W'(i_ticks_per_us);
    assign prod_x = XW'(prod);
    assign max_x  = XW'({DELAY_COUNT_WIDTH{1'b1}});

    always_comb begin
        if (prod == '0) begin
            o_count = DELAY_COUNT_WIDTH'(1);
        end else if (prod_x > max_x) begin
            o_count = {DELAY_COUNT_WIDTH{1'b1}};
        end else begin
            o_count = DELAY_COUNT_WIDTH'(prod_x);
        end
    end

endmodule

[rtl/core/i2cm_seq.sv]
`timescale 1ns / 1ps

module i2cm_seq #(
    parameter int DELAY_COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  i2cm_pkg::t_item   i_item,
    input  i2cm_pkg::t_cfg    i_cfg,
    output i2cm_pkg::t_result o_result
);
    import i2cm_pkg::*;

    t_phase                       r_phase, n_phase;
    logic [DELAY_COUNT_WIDTH-1:0] r_delay, n_delay;
    logic [BIT_IDX_W-1:0]         r_bit, n_bit;
    logic [BYTE_W-1:0]            r_shift, n_shift;
    logic [TIMEOUT_W-1:0]         r_poll, n_poll;
    logic                         r_pend, n_pend;
    logic                         r_scl, n_scl;
    logic                         r_sda, n_sda;
    logic                         r_oe, n_oe;
    logic                         r_err, n_err;
    logic [BYTE_W-1:0]            r_rx, n_rx;

    logic                         enter_en;
    t_phase                       enter_ph;
    logic [US_W-1:0]              enter_us;
    logic [DELAY_COUNT_WIDTH-1:0] enter_cnt;
    logic [DELAY_COUNT_WIDTH-1:0] dec;
    logic [BIT_IDX_W-1:0]         bit_inc;
    logic                         done;

    i2cm_delay_calc #(
        .DELAY_COUNT_WIDTH(DELAY_COUNT_WIDTH)
    ) u_delay_calc (
        .i_us           (enter_us),
        .i_ticks_per_us (i_cfg.ticks_per_us),
        .o_count        (enter_cnt)
    );

    assign dec     = r_delay - DELAY_COUNT_WIDTH'(1);
    assign bit_inc = r_bit + BIT_IDX_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_delay  = r_delay;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_poll   = r_poll;
        n_pend   = r_pend;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_oe     = r_oe;
        n_err    = r_err;
        n_rx     = r_rx;
        enter_en = 1'b0;
        enter_ph = PH_IDLE;
        enter_us = '0;
        done     = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.cmd_valid && (i_item.cmd <= CMD_READ)) begin
                    enter_en = 1'b1;
                    case (i_item.cmd)
                        CMD_START: begin
                            n_oe = 1'b1; n_scl = 1'b1; n_sda = 1'b1;
                            enter_ph = PH_ST_A; enter_us = US_5;
                        end
                        CMD_STOP: begin
                            n_oe = 1'b1; n_scl = 1'b1; n_sda = 1'b0;
                            enter_ph = PH_SP_A; enter_us = US_5;
                        end
                        CMD_WRITE: begin
                            n_oe = 1'b1; n_scl = 1'b0;
                            n_bit   = '0;
                            n_sda   = i_item.tx_byte[BYTE_W-1];
                            n_shift = {i_item.tx_byte[BYTE_W-2:0], 1'b0};
                            enter_ph = PH_WR_SET; enter_us = US_2;
                        end
                        CMD_WAIT: begin
                            n_err = 1'b0; n_oe = 1'b0; n_sda = 1'b1;
                            enter_ph = PH_WA_REL; enter_us = US_1;
                        end
                        default: begin
                            n_oe = 1'b0; n_scl = 1'b0;
                            n_bit   = '0;
                            n_shift = '0;
                            n_pend  = i_item.send_ack;
                            enter_ph = PH_RD_LO; enter_us = US_5;
                        end
                    endcase
                end
            end
            PH_WA_POLL: begin
                if (!i_item.sda_in) begin
                    n_scl = 1'b0;
                    done  = 1'b1;
                end else if (r_poll >= i_cfg.ack_timeout_polls) begin
                    n_err = 1'b1;
                    n_oe = 1'b1; n_scl = 1'b1; n_sda = 1'b0;
                    enter_en = 1'b1; enter_ph = PH_SP_A; enter_us = US_5;
                end else begin
                    n_poll = r_poll + TIMEOUT_W'(1);
                end
            end
            default: begin
                n_delay = dec;
                if (dec == '0) begin
                    case (r_phase)
                        PH_ST_A: begin
                            n_sda = 1'b0;
                            enter_en = 1'b1; enter_ph = PH_ST_B; enter_us = US_6;
                        end
                        PH_ST_B: begin
                            n_scl = 1'b0;
                            enter_en = 1'b1; enter_ph = PH_ST_C; enter_us = US_2;
                        end
                        PH_SP_A: begin
                            n_sda = 1'b1;
                            enter_en = 1'b1; enter_ph = PH_SP_B; enter_us = US_6;
                        end
                        PH_WR_SET: begin
                            n_scl = 1'b1;
                            enter_en = 1'b1; enter_ph = PH_WR_HI; enter_us = US_2;
                        end
                        PH_WR_HI: begin
                            n_scl = 1'b0;
                            enter_en = 1'b1; enter_ph = PH_WR_LO; enter_us = US_2;
                        end
                        PH_WR_LO: begin
                            n_bit = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                done = 1'b1;
                            end else begin
                                n_sda   = r_shift[BYTE_W-1];
                                n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                                enter_en = 1'b1; enter_ph = PH_WR_SET; enter_us = US_2;
                            end
                        end
                        PH_WA_REL: begin
                            n_scl = 1'b1;
                            enter_en = 1'b1; enter_ph = PH_WA_HI; enter_us = US_1;
                        end
                        PH_WA_HI: begin
                            n_phase = PH_WA_POLL;
                            n_poll  = '0;
                        end
                        PH_RD_LO: begin
                            n_scl = 1'b1;
                            enter_en = 1'b1; enter_ph = PH_RD_HI; enter_us = US_2;
                        end
                        PH_RD_HI: begin
                            n_shift = {r_shift[BYTE_W-2:0], i_item.sda_in};
                            enter_en = 1'b1; enter_ph = PH_RD_HOLD; enter_us = US_10;
                        end
                        PH_RD_HOLD: begin
                            n_bit = bit_inc;
                            n_scl = 1'b0;
                            enter_en = 1'b1;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                n_oe  = 1'b1;
                                n_sda = ~r_pend;
                                enter_ph = PH_AK_SET; enter_us = US_2;
                            end else begin
                                enter_ph = PH_RD_LO; enter_us = US_5;
                            end
                        end
                        PH_AK_SET: begin
                            n_scl = 1'b1;
                            enter_en = 1'b1; enter_ph = PH_AK_HI; enter_us = US_5;
                        end
                        PH_AK_HI: begin
                            n_scl = 1'b0;
                            n_rx  = r_shift;
                            done  = 1'b1;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (enter_en) begin
            n_phase = enter_ph;
            n_delay = enter_cnt;
        end
        if (done) begin
            n_phase = PH_IDLE;
            n_delay = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_delay <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_pend  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_oe    <= 1'b1;
            r_err   <= 1'b0;
            r_rx    <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_delay <= n_delay;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_pend  <= n_pend;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_oe    <= n_oe;
            r_err   <= n_err;
            r_rx    <= n_rx;
        end
    end

    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.sda_oe    = n_oe;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_rx;
        o_result.ack_error = n_err;
    end

endmodule

[rtl/core/i2c_master_bit_engine.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  one bus tick: command and sampled SDA
// m_axis    out        m_axis_tvalid / m_axis_tready  line levels and status after the tick
// cfg       in         i_cfg_we                       ticks_per_us, ack_timeout_polls
//
// One transaction in, one out; a new tick is taken every cycle while the output flows.
// Each tick passes the input register, then a sequencer step into the output register.
// A stalled output holds both registers; s_axis_tready drops only when both are full.
// Synchronous active-low reset idles the bus with SCL and SDA high and driven.

module i2c_master_bit_engine #(
    parameter int DELAY_COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd_valid[0], cmd[3:1], tx_byte[11:4], send_ack[12], sda_in[13], zero[15:14]
    input  logic [i2cm_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // scl_out[0], sda_out[1], sda_oe[2], busy_res[3], done_res[4], rx_byte[12:5],
    // ack_error[13], zero[15:14]
    output logic [i2cm_pkg::TDATA_W-1:0]   m_axis_tdata
);
    import i2cm_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    logic    adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_us      <= TICKS_RESET;
            r_cfg.ack_timeout_polls <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TICKS_PER_US: r_cfg.ticks_per_us      <= i_cfg_wdata[TICKS_W-1:0];
                CFG_ACK_TIMEOUT:  r_cfg.ack_timeout_polls <= i_cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[$bits(t_item)-1:0];
        end
        if (adv) begin
            r_out <= step_res;
        end
    end

    i2cm_seq #(
        .DELAY_COUNT_WIDTH(DELAY_COUNT_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

endmodule
